// ----- rtl/tpm_pkg.sv -----
`default_nettype none

package tpm_pkg;

  // Pool geometry
  localparam int TOKEN_COUNT   = 16;
  localparam int PENDING_DEPTH = 64;
  localparam int TAG_WIDTH     = 8;

  // Access classes: 0 BK, 1 BE, 2 VI, 3 VO, 4 beacon
  localparam int NUM_CLASSES   = 5;
  localparam int BEACON_CLASS  = 4;
  localparam int BEACON_TOKENS = 2;
  localparam int FIRST_SPARE   = BEACON_CLASS + BEACON_TOKENS;

  localparam int TOKEN_W = 4;
  localparam int CLASS_W = 3;
  localparam int THR_W   = 7;
  localparam int HEAD_W  = $clog2(PENDING_DEPTH);
  localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
  localparam int PEND_AW = $clog2(NUM_CLASSES * PENDING_DEPTH);

  localparam logic [THR_W-1:0]   THR_RESET      = THR_W'(32);
  localparam logic [CLASS_W-1:0] RR_CLASS_RESET = CLASS_W'(1);

  // Command opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [CLASS_W-1:0]   req_queue;
    logic [TAG_WIDTH-1:0] packet_tag;
    logic [TOKEN_W-1:0]   free_token;
  } cmd_t;

  typedef struct packed {
    logic                 granted;
    logic [TOKEN_W-1:0]   grant_token;
    logic                 queued;
    logic                 dropped;
    logic                 stop_event;
    logic                 released_valid;
    logic [TAG_WIDTH-1:0] released_tag;
    logic                 dispatch_valid;
    logic [TAG_WIDTH-1:0] dispatch_tag;
    logic [CLASS_W-1:0]   dispatch_queue;
    logic                 wake_event;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/tx_token_pool_manager.sv -----
`default_nettype none

// Transmit token pool manager. A command word (allocate or free) is taken
// when start is high and busy is low; exactly one result word follows,
// shown on result for the single cycle in which done is high. The receiver
// cannot stall: whatever is on result while done is high must be captured
// then. Every command, including an allocate with a class above 4, yields
// one result (all zero when ignored). The accept edge issues the reads of
// the owner table and the pending FIFO memory; the execute state uses the
// registered read data, writes the memories back and registers the result.
// busy is high in the execute state, so no new command is taken then.
// stop_threshold is written through cfg_we/cfg_data; the user must write it
// only while no command is in flight: the block does not enforce this. Its
// reset value is 32. No clearing pass is needed after reset.

module tx_token_pool_manager (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire tpm_pkg::cmd_t             cmd,
  output logic                           busy,
  output logic                           done,
  output tpm_pkg::res_t                  result,
  input  wire logic                      cfg_we,
  input  wire logic [tpm_pkg::THR_W-1:0] cfg_data
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // Architectural state kept in flops
  logic [tpm_pkg::THR_W-1:0]       stop_threshold;
  logic [tpm_pkg::TOKEN_COUNT-1:0] token_busy;
  logic [tpm_pkg::NUM_CLASSES-1:0] class_stopped;
  logic [tpm_pkg::CLASS_W-1:0]     next_spare_class;
  logic [tpm_pkg::HEAD_W-1:0]      pending_head  [tpm_pkg::NUM_CLASSES];
  logic [tpm_pkg::CNT_W-1:0]       pending_count [tpm_pkg::NUM_CLASSES];

  // Memories: owner tag per token, one FIFO region per class
  logic [tpm_pkg::TAG_WIDTH-1:0] token_owner   [tpm_pkg::TOKEN_COUNT];
  logic [tpm_pkg::TAG_WIDTH-1:0] pending_store [tpm_pkg::NUM_CLASSES*tpm_pkg::PENDING_DEPTH];
  logic [tpm_pkg::TAG_WIDTH-1:0] owner_rd;
  logic [tpm_pkg::TAG_WIDTH-1:0] pend_rd;

  // Command captured at accept, plus the class picked in the accept cycle
  tpm_pkg::cmd_t               cmd_q;
  logic [tpm_pkg::CLASS_W-1:0] sel_q;
  logic [tpm_pkg::HEAD_W-1:0]  head_q;
  logic [tpm_pkg::CNT_W-1:0]   cnt_q;

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state == S_EXEC);

  // ---------------------------------------------------------------------------
  // Accept cycle: pick the class whose FIFO entry is read
  // ---------------------------------------------------------------------------
  logic [tpm_pkg::NUM_CLASSES-1:0] pend_nz;
  logic [tpm_pkg::CLASS_W-1:0]     rr_class;
  logic [tpm_pkg::CLASS_W-1:0]     sel_a;
  logic [tpm_pkg::PEND_AW-1:0]     pend_raddr;

  always_comb begin
    for (int c = 0; c < tpm_pkg::NUM_CLASSES; c++) begin
      pend_nz[c] = (pending_count[c] != '0);
    end
  end

  // Round robin: first class after next_spare_class with something pending.
  // Scan from the far end so the nearest candidate wins.
  always_comb begin
    logic [tpm_pkg::CLASS_W:0] sum;
    logic [tpm_pkg::CLASS_W-1:0] cand;
    rr_class = next_spare_class;
    for (int i = tpm_pkg::NUM_CLASSES; i >= 1; i--) begin
      sum = {1'b0, next_spare_class} + (tpm_pkg::CLASS_W+1)'(i);
      if (sum >= (tpm_pkg::CLASS_W+1)'(tpm_pkg::NUM_CLASSES)) begin
        sum = sum - (tpm_pkg::CLASS_W+1)'(tpm_pkg::NUM_CLASSES);
      end
      cand = sum[tpm_pkg::CLASS_W-1:0];
      if (pend_nz[cand]) begin
        rr_class = cand;
      end
    end
  end

  always_comb begin
    if (cmd.opcode == tpm_pkg::OP_ALLOC) begin
      if (cmd.req_queue < tpm_pkg::CLASS_W'(tpm_pkg::NUM_CLASSES)) begin
        sel_a = cmd.req_queue;
      end else begin
        sel_a = '0;
      end
    end else if ({1'b0, cmd.free_token} < (tpm_pkg::TOKEN_W+1)'(tpm_pkg::FIRST_SPARE)) begin
      // reserved and beacon tokens serve only their own class
      if (cmd.free_token >= tpm_pkg::TOKEN_W'(tpm_pkg::BEACON_CLASS)) begin
        sel_a = tpm_pkg::CLASS_W'(tpm_pkg::BEACON_CLASS);
      end else begin
        sel_a = cmd.free_token[tpm_pkg::CLASS_W-1:0];
      end
    end else begin
      sel_a = rr_class;
    end
  end

  assign pend_raddr = tpm_pkg::PEND_AW'(sel_a) * tpm_pkg::PEND_AW'(tpm_pkg::PENDING_DEPTH)
                    + tpm_pkg::PEND_AW'(pending_head[sel_a]);

  // ---------------------------------------------------------------------------
  // Execute cycle: decide, write back, form the result word
  // ---------------------------------------------------------------------------
  logic                            f_valid;
  logic                            q_valid;
  logic                            spare_found;
  logic [tpm_pkg::TOKEN_W-1:0]     spare_tok;
  logic                            tok_found;
  logic [tpm_pkg::TOKEN_W-1:0]     tok_sel;
  logic                            is_spare_free;
  logic                            disp;

  logic [tpm_pkg::TOKEN_COUNT-1:0] token_busy_next;
  logic [tpm_pkg::NUM_CLASSES-1:0] class_stopped_next;
  logic [tpm_pkg::CLASS_W-1:0]     next_spare_class_next;
  logic                            fifo_we;
  logic [tpm_pkg::HEAD_W-1:0]      head_next;
  logic [tpm_pkg::CNT_W-1:0]       cnt_next;
  logic                            owner_we;
  logic [tpm_pkg::TOKEN_W-1:0]     owner_waddr;
  logic [tpm_pkg::TAG_WIDTH-1:0]   owner_wdata;
  logic                            pend_we;
  logic [tpm_pkg::PEND_AW-1:0]     pend_waddr;
  logic [tpm_pkg::CNT_W:0]         tail_sum;
  logic [tpm_pkg::HEAD_W-1:0]      tail;
  logic [tpm_pkg::CNT_W-1:0]       cnt_inc;
  logic [tpm_pkg::CNT_W-1:0]       cnt_dec;
  tpm_pkg::res_t                   res_next;

  assign f_valid = ({1'b0, cmd_q.free_token} < (tpm_pkg::TOKEN_W+1)'(tpm_pkg::TOKEN_COUNT));
  assign q_valid = (cmd_q.req_queue < tpm_pkg::CLASS_W'(tpm_pkg::NUM_CLASSES));
  assign is_spare_free =
    ({1'b0, cmd_q.free_token} >= (tpm_pkg::TOKEN_W+1)'(tpm_pkg::FIRST_SPARE));

  // lowest idle spare token
  always_comb begin
    spare_found = 1'b0;
    spare_tok   = '0;
    for (int t = tpm_pkg::TOKEN_COUNT - 1; t >= tpm_pkg::FIRST_SPARE; t--) begin
      if (!token_busy[t]) begin
        spare_found = 1'b1;
        spare_tok   = tpm_pkg::TOKEN_W'(t);
      end
    end
  end

  always_comb begin
    if (cmd_q.req_queue == tpm_pkg::CLASS_W'(tpm_pkg::BEACON_CLASS)) begin
      if (!token_busy[tpm_pkg::BEACON_CLASS]) begin
        tok_found = 1'b1;
        tok_sel   = tpm_pkg::TOKEN_W'(tpm_pkg::BEACON_CLASS);
      end else if (!token_busy[tpm_pkg::BEACON_CLASS+1]) begin
        tok_found = 1'b1;
        tok_sel   = tpm_pkg::TOKEN_W'(tpm_pkg::BEACON_CLASS + 1);
      end else begin
        tok_found = 1'b0;
        tok_sel   = '0;
      end
    end else if (!token_busy[tpm_pkg::TOKEN_W'(cmd_q.req_queue)]) begin
      tok_found = 1'b1;
      tok_sel   = tpm_pkg::TOKEN_W'(cmd_q.req_queue);
    end else begin
      tok_found = spare_found;
      tok_sel   = spare_tok;
    end
  end

  // FIFO tail slot and count arithmetic for the selected class
  assign tail_sum = {1'b0, cnt_q} + (tpm_pkg::CNT_W+1)'(head_q);
  assign tail = (tail_sum >= (tpm_pkg::CNT_W+1)'(tpm_pkg::PENDING_DEPTH))
              ? tpm_pkg::HEAD_W'(tail_sum - (tpm_pkg::CNT_W+1)'(tpm_pkg::PENDING_DEPTH))
              : tpm_pkg::HEAD_W'(tail_sum);
  assign cnt_inc = cnt_q + tpm_pkg::CNT_W'(1);
  assign cnt_dec = cnt_q - tpm_pkg::CNT_W'(1);
  assign disp    = (cnt_q != '0);

  always_comb begin
    res_next              = '0;
    token_busy_next       = token_busy;
    class_stopped_next    = class_stopped;
    next_spare_class_next = next_spare_class;
    fifo_we               = 1'b0;
    head_next             = head_q;
    cnt_next              = cnt_q;
    owner_we              = 1'b0;
    owner_waddr           = cmd_q.free_token;
    owner_wdata           = pend_rd;
    pend_we               = 1'b0;
    pend_waddr = tpm_pkg::PEND_AW'(sel_q) * tpm_pkg::PEND_AW'(tpm_pkg::PENDING_DEPTH)
               + tpm_pkg::PEND_AW'(tail);

    if (cmd_q.opcode == tpm_pkg::OP_ALLOC) begin
      if (q_valid) begin
        if (tok_found) begin
          token_busy_next[tok_sel] = 1'b1;
          owner_we                 = 1'b1;
          owner_waddr              = tok_sel;
          owner_wdata              = cmd_q.packet_tag;
          res_next.granted         = 1'b1;
          res_next.grant_token     = tok_sel;
        end else if (cnt_q >= tpm_pkg::CNT_W'(tpm_pkg::PENDING_DEPTH)) begin
          res_next.dropped = 1'b1;
        end else begin
          pend_we         = 1'b1;
          fifo_we         = 1'b1;
          cnt_next        = cnt_inc;
          res_next.queued = 1'b1;
          if ((cmd_q.req_queue != tpm_pkg::CLASS_W'(tpm_pkg::BEACON_CLASS))
              && (cnt_inc > tpm_pkg::CNT_W'(stop_threshold))) begin
            class_stopped_next[sel_q] = 1'b1;
            res_next.stop_event       = 1'b1;
          end
        end
      end
    end else if (f_valid) begin
      if (token_busy[cmd_q.free_token]) begin
        res_next.released_valid = 1'b1;
        res_next.released_tag   = owner_rd;
      end
      if (disp) begin
        // freed token goes straight to the head of the selected class
        token_busy_next[cmd_q.free_token] = 1'b1;
        owner_we                = 1'b1;
        fifo_we                 = 1'b1;
        cnt_next                = cnt_dec;
        head_next = (head_q == tpm_pkg::HEAD_W'(tpm_pkg::PENDING_DEPTH - 1))
                  ? '0 : head_q + tpm_pkg::HEAD_W'(1);
        if (is_spare_free) begin
          next_spare_class_next = sel_q;
        end
        res_next.dispatch_valid = 1'b1;
        res_next.dispatch_tag   = pend_rd;
        res_next.dispatch_queue = sel_q;
        if (class_stopped[sel_q]
            && ({1'b0, cnt_dec} < (tpm_pkg::CNT_W+1)'(stop_threshold >> 1))) begin
          class_stopped_next[sel_q] = 1'b0;
          res_next.wake_event       = 1'b1;
        end
      end else begin
        token_busy_next[cmd_q.free_token] = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      owner_rd <= token_owner[cmd.free_token];
    end
    if (busy && owner_we) begin
      token_owner[owner_waddr] <= owner_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd <= pending_store[pend_raddr];
    end
    if (busy && pend_we) begin
      pending_store[pend_waddr] <= cmd_q.packet_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Control, state and registered result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      sel_q  <= sel_a;
      head_q <= pending_head[sel_a];
      cnt_q  <= pending_count[sel_a];
    end
    if (busy) begin
      result <= res_next;
    end
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      stop_threshold   <= tpm_pkg::THR_RESET;
      token_busy       <= '0;
      class_stopped    <= '0;
      next_spare_class <= tpm_pkg::RR_CLASS_RESET;
      for (int c = 0; c < tpm_pkg::NUM_CLASSES; c++) begin
        pending_head[c]  <= '0;
        pending_count[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        stop_threshold <= cfg_data;
      end
      done <= busy;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state            <= S_IDLE;
          token_busy       <= token_busy_next;
          class_stopped    <= class_stopped_next;
          next_spare_class <= next_spare_class_next;
          if (fifo_we) begin
            pending_head[sel_q]  <= head_next;
            pending_count[sel_q] <= cnt_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tpm_checker.sv -----
`default_nettype none

module tpm_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire tpm_pkg::res_t result
);

  // accepted word goes into its execute cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // execute lasts one cycle and always yields one result word
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute cycle not followed by a single result word");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a command");

  a_grant_excl: assert property (@(posedge clk) disable iff (rst)
    (done && result.granted) |->
      (!result.queued && !result.dropped && !result.released_valid
       && !result.dispatch_valid))
    else $error("grant mixed with other outcomes");

  a_wake_disp: assert property (@(posedge clk) disable iff (rst)
    (done && (result.wake_event || result.stop_event)) |->
      (result.dispatch_valid || result.queued))
    else $error("stop/wake without queue activity");

endmodule

bind tx_token_pool_manager tpm_checker u_tpm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
